@@ hw/rtl/cdu_pkg.sv @@
// Shared constants and types of the complex divider unit.
package cdu_pkg;

   // Width of every operand and quotient part, and its fraction bits.
   localparam int W = 32;
   localparam int F = 16;
   // Width of a product or of a numerator magnitude.
   localparam int PW = 2 * W;
   // Signed width of a numerator sum.
   localparam int SW = PW + 1;
   // Width of the partial remainder loaded before the first quotient bit.
   localparam int RW = W + F;
   // One divider step per quotient bit.
   localparam int NSTEP = W;

   localparam logic [W-1:0] Q_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] Q_MIN = {1'b1, {(W-1){1'b0}}};

   // Numerators and denominator handed from the front end to the divider.
   typedef struct packed {
      logic          valid;
      logic [PW-1:0] num_re;
      logic [PW-1:0] num_im;
      logic          neg_re;
      logic          neg_im;
      logic [PW-1:0] den;
   } num_type;

   // One lane of the restoring divider between two steps.
   typedef struct packed {
      logic [PW-1:0] rem;
      logic [W-1:0]  low;
      logic [W-1:0]  quo;
      logic          neg;
      logic          ovf;
   } lane_type;

endpackage

@@ hw/rtl/cdu_req_if.sv @@
// Request channel interface: dividend and divisor parts.
interface cdu_req_if;
   logic                   valid;
   logic                   ready;
   logic [cdu_pkg::W-1:0]  a_re;
   logic [cdu_pkg::W-1:0]  a_im;
   logic [cdu_pkg::W-1:0]  b_re;
   logic [cdu_pkg::W-1:0]  b_im;

   modport source (output valid, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, a_re, a_im, b_re, b_im, output ready);
endinterface

@@ hw/rtl/cdu_rsp_if.sv @@
// Response channel interface: quotient parts and status flags.
interface cdu_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [cdu_pkg::W-1:0]  q_re;
   logic [cdu_pkg::W-1:0]  q_im;
   logic                   saturated;
   logic                   div_by_zero;

   modport source (output valid, q_re, q_im, saturated, div_by_zero, input ready);
   modport sink   (input valid, q_re, q_im, saturated, div_by_zero, output ready);
endinterface

@@ hw/rtl/cdu_front.sv @@
// Front end: magnitudes, cross products, numerator sums and denominator.
module cdu_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic [cdu_pkg::W-1:0]   a_re,
   input  logic [cdu_pkg::W-1:0]   a_im,
   input  logic [cdu_pkg::W-1:0]   b_re,
   input  logic [cdu_pkg::W-1:0]   b_im,
   output cdu_pkg::num_type        num_o
);
   localparam int W  = cdu_pkg::W;
   localparam int PW = cdu_pkg::PW;
   localparam int SW = cdu_pkg::SW;

   logic [4:0] vld_ff;

   // Stage 1: sign and magnitude of each part.
   logic [W-1:0] mar_ff, mai_ff, mbr_ff, mbi_ff;
   logic [W-1:0] mar_in, mai_in, mbr_in, mbi_in;
   logic         nar_ff, nai_ff, nbr_ff, nbi_ff;
   // Stage 2: unsigned products and the signs of the cross terms.
   logic [PW-1:0] p_arbr_ff, p_aibi_ff, p_aibr_ff, p_arbi_ff, p_brbr_ff, p_bibi_ff;
   logic          s_arbr_ff, s_aibi_ff, s_aibr_ff, s_arbi_ff;
   // Stage 3: signed terms and denominator.
   logic [SW-1:0] t1_ff, t2_ff, t3_ff, t4_ff;
   logic [SW-1:0] t1_in, t2_in, t3_in, t4_in;
   logic [PW-1:0] den3_ff;
   // Stage 4: signed numerators.
   logic [SW-1:0] sre_ff, sim_ff;
   logic [PW-1:0] den4_ff;
   // Stage 5: numerator magnitudes.
   logic [PW-1:0] nre_ff, nim_ff, den5_ff;
   logic          neg_re_ff, neg_im_ff;

   always_comb begin
      mar_in = a_re[W-1] ? (~a_re + 1'b1) : a_re;
      mai_in = a_im[W-1] ? (~a_im + 1'b1) : a_im;
      mbr_in = b_re[W-1] ? (~b_re + 1'b1) : b_re;
      mbi_in = b_im[W-1] ? (~b_im + 1'b1) : b_im;
   end

   always_comb begin
      t1_in = s_arbr_ff ? (~{1'b0, p_arbr_ff} + 1'b1) : {1'b0, p_arbr_ff};
      t2_in = s_aibi_ff ? (~{1'b0, p_aibi_ff} + 1'b1) : {1'b0, p_aibi_ff};
      t3_in = s_aibr_ff ? (~{1'b0, p_aibr_ff} + 1'b1) : {1'b0, p_aibr_ff};
      t4_in = s_arbi_ff ? (~{1'b0, p_arbi_ff} + 1'b1) : {1'b0, p_arbi_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mar_ff <= mar_in;
         mai_ff <= mai_in;
         mbr_ff <= mbr_in;
         mbi_ff <= mbi_in;
         nar_ff <= a_re[W-1];
         nai_ff <= a_im[W-1];
         nbr_ff <= b_re[W-1];
         nbi_ff <= b_im[W-1];

         p_arbr_ff <= PW'(mar_ff) * PW'(mbr_ff);
         p_aibi_ff <= PW'(mai_ff) * PW'(mbi_ff);
         p_aibr_ff <= PW'(mai_ff) * PW'(mbr_ff);
         p_arbi_ff <= PW'(mar_ff) * PW'(mbi_ff);
         p_brbr_ff <= PW'(mbr_ff) * PW'(mbr_ff);
         p_bibi_ff <= PW'(mbi_ff) * PW'(mbi_ff);
         s_arbr_ff <= nar_ff ^ nbr_ff;
         s_aibi_ff <= nai_ff ^ nbi_ff;
         s_aibr_ff <= nai_ff ^ nbr_ff;
         // The ar*bi term is subtracted, so its sign is inverted.
         s_arbi_ff <= ~(nar_ff ^ nbi_ff);

         t1_ff   <= t1_in;
         t2_ff   <= t2_in;
         t3_ff   <= t3_in;
         t4_ff   <= t4_in;
         den3_ff <= p_brbr_ff + p_bibi_ff;

         sre_ff  <= t1_ff + t2_ff;
         sim_ff  <= t3_ff + t4_ff;
         den4_ff <= den3_ff;

         nre_ff    <= sre_ff[SW-1] ? PW'(~sre_ff + 1'b1) : sre_ff[PW-1:0];
         nim_ff    <= sim_ff[SW-1] ? PW'(~sim_ff + 1'b1) : sim_ff[PW-1:0];
         neg_re_ff <= sre_ff[SW-1];
         neg_im_ff <= sim_ff[SW-1];
         den5_ff   <= den4_ff;
      end
   end

   always_comb begin
      num_o.valid  = vld_ff[4];
      num_o.num_re = nre_ff;
      num_o.num_im = nim_ff;
      num_o.neg_re = neg_re_ff;
      num_o.neg_im = neg_im_ff;
      num_o.den    = den5_ff;
   end
endmodule

@@ hw/rtl/cdu_div_step.sv @@
// One restoring division step: brings in one dividend bit, yields one quotient bit.
module cdu_div_step (
   input  cdu_pkg::lane_type          lane_i,
   input  logic [cdu_pkg::PW-1:0]     den,
   output cdu_pkg::lane_type          lane_o
);
   localparam int W  = cdu_pkg::W;
   localparam int PW = cdu_pkg::PW;

   logic [PW:0] trial;
   logic [PW:0] diff;
   logic        ge;

   always_comb begin
      trial = {lane_i.rem, lane_i.low[W-1]};
      diff  = trial - {1'b0, den};
      ge    = trial >= {1'b0, den};
      lane_o.rem = ge ? diff[PW-1:0] : trial[PW-1:0];
      lane_o.low = {lane_i.low[W-2:0], 1'b0};
      lane_o.quo = {lane_i.quo[W-2:0], ge};
      lane_o.neg = lane_i.neg;
      lane_o.ovf = lane_i.ovf;
   end
endmodule

@@ hw/rtl/cdu_divider.sv @@
// Pipelined restoring divider for both quotient parts, with saturation and sign.
module cdu_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  cdu_pkg::num_type        num_i,
   output logic                    out_valid,
   output logic [cdu_pkg::W-1:0]   q_re,
   output logic [cdu_pkg::W-1:0]   q_im,
   output logic                    saturated,
   output logic                    div_by_zero
);
   localparam int W     = cdu_pkg::W;
   localparam int F     = cdu_pkg::F;
   localparam int PW    = cdu_pkg::PW;
   localparam int RW    = cdu_pkg::RW;
   localparam int NSTEP = cdu_pkg::NSTEP;

   logic [NSTEP:0]     vld_ff;
   cdu_pkg::lane_type  re_ff  [NSTEP+1];
   cdu_pkg::lane_type  im_ff  [NSTEP+1];
   logic [PW-1:0]      den_ff [NSTEP+1];
   cdu_pkg::lane_type  re_step [NSTEP];
   cdu_pkg::lane_type  im_step [NSTEP];
   cdu_pkg::lane_type  re0_in, im0_in;

   logic               vout_ff;
   logic [W-1:0]       qre_ff, qim_ff;
   logic               sat_ff, dbz_ff;
   logic [W:0]         fre, fim;
   logic               dbz;

   // Saturating, signed result of one lane: {saturated, quotient}.
   function automatic logic [W:0] finish(cdu_pkg::lane_type l);
      logic [W-1:0] lim;
      logic [W-1:0] mag;
      logic         sat;
      lim = {1'b0, {(W-1){1'b1}}} + W'(l.neg);
      sat = l.ovf || (l.quo > lim);
      mag = sat ? lim : l.quo;
      return {sat, l.neg ? (~mag + 1'b1) : mag};
   endfunction

   // Setup: the top bits of num * 2^F form the first partial remainder; if it
   // already reaches the denominator the quotient cannot fit.
   always_comb begin
      re0_in.rem = PW'(num_i.num_re[PW-1 -: RW]);
      re0_in.low = {num_i.num_re[W-F-1:0], F'(0)};
      re0_in.quo = '0;
      re0_in.neg = num_i.neg_re;
      re0_in.ovf = PW'(num_i.num_re[PW-1 -: RW]) >= num_i.den;
      im0_in.rem = PW'(num_i.num_im[PW-1 -: RW]);
      im0_in.low = {num_i.num_im[W-F-1:0], F'(0)};
      im0_in.quo = '0;
      im0_in.neg = num_i.neg_im;
      im0_in.ovf = PW'(num_i.num_im[PW-1 -: RW]) >= num_i.den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         vout_ff <= 1'b0;
      end else if (adv) begin
         vld_ff  <= {vld_ff[NSTEP-1:0], num_i.valid};
         vout_ff <= vld_ff[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         re_ff[0]  <= re0_in;
         im_ff[0]  <= im0_in;
         den_ff[0] <= num_i.den;
      end
   end

   for (genvar i = 0; i < NSTEP; i++) begin : g_step
      cdu_div_step u_re (.lane_i(re_ff[i]), .den(den_ff[i]), .lane_o(re_step[i]));
      cdu_div_step u_im (.lane_i(im_ff[i]), .den(den_ff[i]), .lane_o(im_step[i]));

      always_ff @(posedge clock) begin
         if (adv) begin
            re_ff[i+1]  <= re_step[i];
            im_ff[i+1]  <= im_step[i];
            den_ff[i+1] <= den_ff[i];
         end
      end
   end

   always_comb begin
      fre = finish(re_ff[NSTEP]);
      fim = finish(im_ff[NSTEP]);
      dbz = den_ff[NSTEP] == '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qre_ff <= dbz ? '0 : fre[W-1:0];
         qim_ff <= dbz ? '0 : fim[W-1:0];
         sat_ff <= !dbz && (fre[W] || fim[W]);
         dbz_ff <= dbz;
      end
   end

   assign out_valid   = vout_ff;
   assign q_re        = qre_ff;
   assign q_im        = qim_ff;
   assign saturated   = sat_ff;
   assign div_by_zero = dbz_ff;
endmodule

@@ hw/rtl/complex_divider_unit.sv @@
// Top level of the pipelined complex divider.
//
//   Channel | Direction | Contents
//   --------+-----------+--------------------------------------------------
//   req     | in        | a_re, a_im, b_re, b_im: signed Q16.16 operands
//   rsp     | out       | q_re, q_im (signed Q16.16), saturated, div_by_zero
//
// One transfer per cycle is taken on req and given on rsp when rsp is not stalled.
// The pipeline has five front-end stages (magnitudes, products, signed terms,
// sums, magnitudes), one setup stage, one divider stage per quotient bit (32),
// and the output register.
// Reset clears only the valid bits of the pipeline.
// When the output register holds a result that rsp does not take, the whole
// pipeline holds, and req.ready falls in the same cycle.
module complex_divider_unit (
   input  logic        clock,
   input  logic        reset,
   cdu_req_if.sink     req,
   cdu_rsp_if.source   rsp
);
   // The pipeline moves as a whole whenever the output register is empty or
   // its result is being transferred this cycle.
   logic             adv;
   cdu_pkg::num_type num;

   assign adv       = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   cdu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req.valid),
      .a_re     (req.a_re),
      .a_im     (req.a_im),
      .b_re     (req.b_re),
      .b_im     (req.b_im),
      .num_o    (num)
   );

   // Both quotient parts share one denominator; a zero denominator forces
   // zero outputs and the divide-by-zero flag at the last stage.
   cdu_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .num_i       (num),
      .out_valid   (rsp.valid),
      .q_re        (rsp.q_re),
      .q_im        (rsp.q_im),
      .saturated   (rsp.saturated),
      .div_by_zero (rsp.div_by_zero)
   );
endmodule

@@ hw/rtl/cdu_checker.sv @@
// Port-level checks of the complex divider unit, bound to the top level.
module cdu_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [cdu_pkg::W-1:0]  rsp_q_re,
   input logic [cdu_pkg::W-1:0]  rsp_q_im,
   input logic                   rsp_saturated,
   input logic                   rsp_div_by_zero
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_q_re) && $stable(rsp_q_im))
      else $error("rsp payload changed while stalled");

   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |-> rsp_q_re == '0 && rsp_q_im == '0 && !rsp_saturated)
      else $error("divide by zero without zero result");

   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_q_re == cdu_pkg::Q_MAX || rsp_q_re == cdu_pkg::Q_MIN ||
         rsp_q_im == cdu_pkg::Q_MAX || rsp_q_im == cdu_pkg::Q_MIN)
      else $error("saturated flag without a clamped part");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output register");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind complex_divider_unit cdu_checker u_cdu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_q_re        (rsp.q_re),
   .rsp_q_im        (rsp.q_im),
   .rsp_saturated   (rsp.saturated),
   .rsp_div_by_zero (rsp.div_by_zero)
);
